// ===== rtl/fis_pkg.sv =====
// ----------------------------------------------------------------------------
// fis_pkg: shared types and constants for the escape-time fractal iterator
// Sequencer states, control/status bundles, register indexes, reset values
// and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package fis_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_SQ,
    ST_UPD,
    ST_DONE
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic map_sel;   // multiplier takes the pixel mapping operands
    logic load_pt;   // load the mapped point into z (mode 0) or into c (mode 1)
    logic iterate;   // escape check and z update
    logic done;      // result word on the output ports
    logic busy;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic limit_zero;
    logic stop;
  } status_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_RE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C_IM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_Y   = 3'd7;

  localparam logic              RST_MODE   = 1'b0;
  localparam logic signed [31:0] RST_C_RE  = -32'sd93952410;
  localparam logic signed [31:0] RST_C_IM  = 32'sd36258869;
  localparam logic [11:0]        RST_MAX_IT = 12'd300;
  localparam logic [30:0]        RST_X_STEP = 31'd629146;
  localparam logic [30:0]        RST_Y_STEP = 31'd559241;
  localparam logic signed [31:0] RST_MOVE   = 32'sd0;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/fis_mul3.sv =====
// ----------------------------------------------------------------------------
// fis_mul3: shared three-product multiplier
// p0 = a0*b0, p1 = a1*b1, p2 = a0*b1, all signed 32x32, registered.
// ----------------------------------------------------------------------------
module fis_mul3
  import fis_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] a0,
  input  logic signed [31:0] b0,
  input  logic signed [31:0] a1,
  input  logic signed [31:0] b1,
  output logic signed [63:0] p0,
  output logic signed [63:0] p1,
  output logic signed [63:0] p2
);

  always_ff @(posedge clk) begin
    p0 <= 64'(a0) * 64'(b0);
    p1 <= 64'(a1) * 64'(b1);
    p2 <= 64'(a0) * 64'(b1);
  end

endmodule

// ===== rtl/fis_ctrl.sv =====
// ----------------------------------------------------------------------------
// fis_ctrl: iteration sequencer
// Map point, then alternate square and update/check until stop; a zero limit goes straight to done.
// ----------------------------------------------------------------------------
module fis_ctrl
  import fis_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t sts,
  output ctrl_t   ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_MAP_MUL;
      ST_MAP_MUL: state_next = ST_MAP_ADD;
      ST_MAP_ADD: state_next = sts.limit_zero ? ST_DONE : ST_SQ;
      ST_SQ:      state_next = ST_UPD;
      ST_UPD:     state_next = sts.stop ? ST_DONE : ST_SQ;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.busy = 1'b0;
      end
      ST_MAP_MUL: begin
        ctl.busy    = 1'b1;
        ctl.map_sel = 1'b1;
      end
      ST_MAP_ADD: begin
        ctl.busy    = 1'b1;
        ctl.load_pt = 1'b1;
      end
      ST_SQ: begin
        ctl.busy = 1'b1;
      end
      ST_UPD: begin
        ctl.busy    = 1'b1;
        ctl.iterate = 1'b1;
      end
      ST_DONE: begin
        ctl.busy = 1'b1;
        ctl.done = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== rtl/escape_time_fractal_iterator.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator: Mandelbrot / Julia escape-time counter
// Maps a pixel to a Q(32-FRAC_BITS).FRAC_BITS point, iterates z = z*z + c on
// one shared three-product multiplier and reports count, escape and hue.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------
//  pixel in | start, busy          | pixel_x, pixel_y
//  result   | done (1-cycle pulse) | iteration_count, escaped, hue
//  config   | cfg_we (no wait)     | cfg_index, cfg_data
//
//  Order: a word is taken when start is high and busy is low. The point is
//  mapped (ST_MAP_MUL, ST_MAP_ADD), then ST_SQ and ST_UPD alternate until the
//  limit is reached or the point escapes, and ST_DONE raises the strobe; a
//  limit of zero goes from ST_MAP_ADD straight to ST_DONE. busy drops the cycle after done.
//  Each iteration passes through the shared multiplier (re^2, im^2, re*im)
//  in ST_SQ, then does the escape check and z update in ST_UPD.
//  Reset clears the sequencer and loads the default register values.
//  The receiver cannot stall: done marks one cycle only, outputs hold after.
//
module escape_time_fractal_iterator
  import fis_pkg::*;
#(
  parameter int WIDTH     = 640,
  parameter int HEIGHT    = 480,
  parameter int FRAC_BITS = 27
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [9:0]            pixel_x,
  input  logic [9:0]            pixel_y,
  output logic                  done,
  output logic [11:0]           iteration_count,
  output logic                  escaped,
  output logic [7:0]            hue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // escape threshold 4.0 in the squared scale, wide enough for any FRAC_BITS
  localparam int MAGW = (2 * FRAC_BITS + 3 > 65) ? 2 * FRAC_BITS + 3 : 65;
  localparam logic [MAGW-1:0] THRESH = MAGW'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [11:0] HALF_X = 12'(WIDTH / 2);
  localparam logic signed [11:0] HALF_Y = 12'(HEIGHT / 2);

  // configuration registers
  logic               mode;
  logic signed [31:0] julia_c_re;
  logic signed [31:0] julia_c_im;
  logic [11:0]        max_iterations;
  logic [30:0]        x_step;
  logic [30:0]        y_step;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= RST_MODE;
      julia_c_re     <= RST_C_RE;
      julia_c_im     <= RST_C_IM;
      max_iterations <= RST_MAX_IT;
      x_step         <= RST_X_STEP;
      y_step         <= RST_Y_STEP;
      move_x         <= RST_MOVE;
      move_y         <= RST_MOVE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode           <= cfg_data[0];
        REG_C_RE:   julia_c_re     <= cfg_data;
        REG_C_IM:   julia_c_im     <= cfg_data;
        REG_MAX_IT: max_iterations <= cfg_data[11:0];
        REG_X_STEP: x_step         <= cfg_data[30:0];
        REG_Y_STEP: y_step         <= cfg_data[30:0];
        REG_MOVE_X: move_x         <= cfg_data;
        REG_MOVE_Y: move_y         <= cfg_data;
        default:    mode           <= mode;
      endcase
    end
  end

  ctrl_t   ctl;
  status_t sts;

  fis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl)
  );

  // item registers
  logic [9:0]         px;
  logic [9:0]         py;
  logic signed [31:0] zre;
  logic signed [31:0] zim;
  logic signed [31:0] cre;
  logic signed [31:0] cim;
  logic [11:0]        count;
  logic               esc;
  logic               first;   // no iterate done yet: nothing to check

  // shared multiplier operands
  logic signed [11:0] offx;
  logic signed [11:0] offy;
  logic signed [31:0] a0, b0, a1, b1;
  logic signed [63:0] p0, p1, p2;

  always_comb begin
    offx = $signed({2'b00, px}) - HALF_X;
    offy = $signed({2'b00, py}) - HALF_Y;
    if (ctl.map_sel) begin
      a0 = $signed({1'b0, x_step});
      b0 = 32'(offx);
      a1 = $signed({1'b0, y_step});
      b1 = 32'(offy);
    end else begin
      a0 = zre;
      b0 = zre;
      a1 = zim;
      b1 = zim;
    end
  end

  fis_mul3 u_mul (
    .clk (clk),
    .a0  (a0),
    .b0  (b0),
    .a1  (a1),
    .b1  (b1),
    .p0  (p0),
    .p1  (p1),
    .p2  (p2)
  );

  // mapping: step*offset + move, saturated
  logic signed [31:0] pt_re;
  logic signed [31:0] pt_im;
  // iteration: floor-shift the products, add c, saturate
  logic signed [65:0] re_sh;
  logic signed [65:0] im_sh;
  logic signed [31:0] zre_next;
  logic signed [31:0] zim_next;
  // escape test on the current z, whose squares sit in p0/p1
  logic [64:0]        mag;
  logic               escape;
  logic [11:0]        count_inc;
  logic               last;

  always_comb begin
    pt_re     = sat32(66'(p0) + 66'(move_x));
    pt_im     = sat32(66'(p1) + 66'(move_y));
    re_sh     = (66'(p0) - 66'(p1)) >>> FRAC_BITS;
    im_sh     = 66'(p2) >>> (FRAC_BITS - 1);
    zre_next  = sat32(re_sh + 66'(cre));
    zim_next  = sat32(im_sh + 66'(cim));
    mag       = {1'b0, p0} + {1'b0, p1};
    escape    = MAGW'(mag) > THRESH;
    count_inc = count + 12'd1;
    last      = count_inc == max_iterations;
    sts.limit_zero = max_iterations == 12'd0;
    sts.stop       = !first && (escape || last);
  end

  always_ff @(posedge clk) begin
    if (start && !ctl.busy) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (ctl.load_pt) begin
      count <= '0;
      esc   <= 1'b0;
      first <= 1'b1;
      if (mode) begin
        zre <= '0;
        zim <= '0;
        cre <= pt_re;
        cim <= pt_im;
      end else begin
        zre <= pt_re;
        zim <= pt_im;
        cre <= julia_c_re;
        cim <= julia_c_im;
      end
    end
    if (ctl.iterate) begin
      if (!first) begin
        if (escape) begin
          esc <= 1'b1;
        end else begin
          count <= count_inc;
        end
      end
      if (!sts.stop) begin
        zre   <= zre_next;
        zim   <= zim_next;
        first <= 1'b0;
      end
    end
  end

  assign busy            = ctl.busy;
  assign done            = ctl.done;
  assign iteration_count = count;
  assign escaped         = esc;
  assign hue             = count[7:0];

  // result strobe lasts a single cycle
  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted pixel makes the block busy
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after start");

  // a checked, non-escaping iteration that continues advances the count by one
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (ctl.iterate && !first && !escape && !sts.stop) |=> count == $past(count_inc))
    else $error("iteration count did not advance");

  // the sequencer never stops early on an unchecked first update
  a_first_runs : assert property (@(posedge clk) disable iff (rst)
    (ctl.iterate && first) |=> !first && busy && !done)
    else $error("first update ended the item");

endmodule
